// ----- sv/indexed_multi_queue_list_macros.svh -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list assertion macros
// Shared assertion macros for the queue manager. They are empty when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MULTI_QUEUE_LIST_MACROS_SVH
`define INDEXED_MULTI_QUEUE_LIST_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every edge outside reset.
`define IMQL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define IMQL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IMQL_ASSERT(label, clk, rst, prop, msg)

`define IMQL_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ----- sv/imql_pkg.sv -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list package
// Transfer types, request codes and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package imql_pkg;

   localparam logic [1:0] REQ_ENQUEUE = 2'd0;
   localparam logic [1:0] REQ_DEQUEUE = 2'd1;
   localparam logic [1:0] REQ_REMOVE  = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] queue_id;
      logic [5:0] item_id;
   } request_type;

   typedef struct packed {
      logic [6:0] popped_id;
      logic       was_empty;
   } response_type;

   typedef enum logic [3:0] {
      STEP_IDLE,
      STEP_CLEAR,
      STEP_ENQ_READ,
      STEP_ENQ_LINK,
      STEP_ENQ_DONE,
      STEP_DEQ_READ,
      STEP_DEQ_NEXT,
      STEP_DEQ_LINK,
      STEP_DEQ_DONE,
      STEP_DEQ_EMPTY,
      STEP_REM_READ,
      STEP_REM_LINK,
      STEP_REM_DONE,
      STEP_NOP
   } step_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_TAIL_NULL,
      COND_TAIL_OK,
      COND_HEAD_NULL,
      COND_NEXT_NULL,
      COND_NEXT_OK,
      COND_HEAD_IS_ITEM,
      COND_HEAD_LINK_PREV,
      COND_TAIL_IS_ITEM,
      COND_TAIL_LINK_NEXT,
      COND_SWEEP_LAST
   } cond_type;

   typedef enum logic [2:0] {
      SRC_NULL,
      SRC_ITEM,
      SRC_HEAD,
      SRC_TAIL,
      SRC_PREV,
      SRC_NEXT
   } src_type;

   typedef enum logic [1:0] {
      RES_NONE,
      RES_POP,
      RES_EMPTY
   } res_type;

   typedef struct packed {
      logic tail_null;
      logic head_null;
      logic next_null;
      logic prev_null;
      logic head_is_item;
      logic tail_is_item;
      logic sweep_last;
   } flags_type;

   typedef struct packed {
      logic     dispatch;
      logic     sweep;
      logic     head_rd;
      logic     tail_rd;
      logic     prev_rd;
      logic     next_rd;
      src_type  next_ra;
      cond_type head_we;
      src_type  head_wd;
      cond_type tail_we;
      src_type  tail_wd;
      cond_type prev_we;
      src_type  prev_wa;
      src_type  prev_wd;
      cond_type next_we;
      src_type  next_wa;
      src_type  next_wd;
      logic     done;
      res_type  res;
      cond_type jmp_cond;
      step_type jmp_target;
      step_type next_step;
   } ctrl_type;

   function automatic logic cond_eval(cond_type c, flags_type f);
      logic r;
      case (c)
         COND_NEVER:          r = 1'b0;
         COND_ALWAYS:         r = 1'b1;
         COND_TAIL_NULL:      r = f.tail_null;
         COND_TAIL_OK:        r = !f.tail_null;
         COND_HEAD_NULL:      r = f.head_null;
         COND_NEXT_NULL:      r = f.next_null;
         COND_NEXT_OK:        r = !f.next_null;
         COND_HEAD_IS_ITEM:   r = f.head_is_item;
         COND_HEAD_LINK_PREV: r = !f.head_is_item && !f.prev_null;
         COND_TAIL_IS_ITEM:   r = f.tail_is_item;
         COND_TAIL_LINK_NEXT: r = !f.tail_is_item && !f.next_null;
         COND_SWEEP_LAST:     r = f.sweep_last;
         default:             r = 1'b0;
      endcase
      return r;
   endfunction

   // Microcode program, one control word per step.
   function automatic ctrl_type ucode_word(step_type s);
      ctrl_type w;
      w = '0;
      w.next_step = STEP_IDLE;
      case (s)
         STEP_IDLE: begin
            w.dispatch = 1'b1;
         end
         STEP_CLEAR: begin
            w.sweep      = 1'b1;
            w.head_we    = COND_ALWAYS;
            w.tail_we    = COND_ALWAYS;
            w.prev_we    = COND_ALWAYS;
            w.next_we    = COND_ALWAYS;
            w.jmp_cond   = COND_SWEEP_LAST;
            w.jmp_target = STEP_IDLE;
            w.next_step  = STEP_CLEAR;
         end
         STEP_ENQ_READ: begin
            w.tail_rd   = 1'b1;
            w.next_step = STEP_ENQ_LINK;
         end
         STEP_ENQ_LINK: begin
            w.next_we   = COND_TAIL_OK;
            w.next_wa   = SRC_TAIL;
            w.next_wd   = SRC_ITEM;
            w.prev_we   = COND_ALWAYS;
            w.prev_wa   = SRC_ITEM;
            w.prev_wd   = SRC_TAIL;
            w.tail_we   = COND_ALWAYS;
            w.tail_wd   = SRC_ITEM;
            w.head_we   = COND_TAIL_NULL;
            w.head_wd   = SRC_ITEM;
            w.next_step = STEP_ENQ_DONE;
         end
         STEP_ENQ_DONE: begin
            w.next_we = COND_ALWAYS;
            w.next_wa = SRC_ITEM;
            w.next_wd = SRC_NULL;
            w.done    = 1'b1;
            w.res     = RES_NONE;
         end
         STEP_DEQ_READ: begin
            w.head_rd   = 1'b1;
            w.next_step = STEP_DEQ_NEXT;
         end
         STEP_DEQ_NEXT: begin
            w.next_rd    = 1'b1;
            w.next_ra    = SRC_HEAD;
            w.jmp_cond   = COND_HEAD_NULL;
            w.jmp_target = STEP_DEQ_EMPTY;
            w.next_step  = STEP_DEQ_LINK;
         end
         STEP_DEQ_LINK: begin
            w.head_we   = COND_ALWAYS;
            w.head_wd   = SRC_NEXT;
            w.tail_we   = COND_NEXT_NULL;
            w.tail_wd   = SRC_NULL;
            w.prev_we   = COND_NEXT_OK;
            w.prev_wa   = SRC_NEXT;
            w.prev_wd   = SRC_NULL;
            w.next_we   = COND_ALWAYS;
            w.next_wa   = SRC_HEAD;
            w.next_wd   = SRC_NULL;
            w.next_step = STEP_DEQ_DONE;
         end
         STEP_DEQ_DONE: begin
            w.prev_we = COND_ALWAYS;
            w.prev_wa = SRC_HEAD;
            w.prev_wd = SRC_NULL;
            w.done    = 1'b1;
            w.res     = RES_POP;
         end
         STEP_DEQ_EMPTY: begin
            w.head_we = COND_ALWAYS;
            w.head_wd = SRC_NULL;
            w.tail_we = COND_ALWAYS;
            w.tail_wd = SRC_NULL;
            w.done    = 1'b1;
            w.res     = RES_EMPTY;
         end
         STEP_REM_READ: begin
            w.head_rd   = 1'b1;
            w.tail_rd   = 1'b1;
            w.prev_rd   = 1'b1;
            w.next_rd   = 1'b1;
            w.next_ra   = SRC_ITEM;
            w.next_step = STEP_REM_LINK;
         end
         STEP_REM_LINK: begin
            w.head_we   = COND_HEAD_IS_ITEM;
            w.head_wd   = SRC_NEXT;
            w.next_we   = COND_HEAD_LINK_PREV;
            w.next_wa   = SRC_PREV;
            w.next_wd   = SRC_NEXT;
            w.tail_we   = COND_TAIL_IS_ITEM;
            w.tail_wd   = SRC_PREV;
            w.prev_we   = COND_TAIL_LINK_NEXT;
            w.prev_wa   = SRC_NEXT;
            w.prev_wd   = SRC_PREV;
            w.next_step = STEP_REM_DONE;
         end
         STEP_REM_DONE: begin
            w.prev_we = COND_ALWAYS;
            w.prev_wa = SRC_ITEM;
            w.prev_wd = SRC_NULL;
            w.next_we = COND_ALWAYS;
            w.next_wa = SRC_ITEM;
            w.next_wd = SRC_NULL;
            w.done    = 1'b1;
            w.res     = RES_NONE;
         end
         STEP_NOP: begin
            w.done = 1'b1;
            w.res  = RES_NONE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- sv/indexed_multi_queue_list.sv -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list
// Keeps ITEM_COUNT+1 FIFO queues of item ids as doubly linked lists in head,
// tail, prev and next memories; a microcoded sequencer runs each request.
//
// The request channel carries one request per transfer: enqueue an item at a
// queue's tail, dequeue a queue's head, or unlink a given item. Every request
// produces exactly one response transfer with the popped id (null otherwise)
// and an empty flag. Requests with an out-of-range queue or item, or an
// unknown code, change nothing.
// One request is in work at a time: the block takes no new request until
// the dependent read-then-write steps of the last one on the memories are
// done. The response appears in the register in the cycle after the last
// step. After reset a clearing pass writes null into every entry, during
// which req_stall stays high.
// While rsp_stall holds a response, a new request is still taken and run up
// to its last step, which then waits until the output register is free.
// ----------------------------------------------------------------------------
`include "indexed_multi_queue_list_macros.svh"

module indexed_multi_queue_list
   import imql_pkg::*;
#(
   parameter int ITEM_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  request_type  req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output response_type rsp_data
);

   ctrl_type     ctrl;
   flags_type    flags;
   response_type result;
   logic         step_go;
   logic         req_take;
   logic         out_busy;
   logic         rsp_load;
   logic         rsp_valid_ff;
   logic         rsp_valid_ff_in;
   response_type rsp_data_ff;
   response_type rsp_data_ff_in;

   imql_sequencer #(
      .ITEM_COUNT (ITEM_COUNT)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .out_busy  (out_busy),
      .flags     (flags),
      .req_stall (req_stall),
      .req_take  (req_take),
      .ctrl      (ctrl),
      .step_go   (step_go)
   );

   imql_datapath #(
      .ITEM_COUNT (ITEM_COUNT)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_take (req_take),
      .req_data (req_data),
      .ctrl     (ctrl),
      .step_go  (step_go),
      .flags    (flags),
      .result   (result)
   );

   always_comb begin
      out_busy        = rsp_valid_ff && rsp_stall;
      rsp_load        = ctrl.done && step_go;
      rsp_valid_ff_in = rsp_load || out_busy;
      rsp_data_ff_in  = rsp_load ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_ff_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_ff_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `IMQL_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && rsp_stall) |-> !rsp_load, "a held response must not be overwritten")

endmodule

// ----- sv/imql_ram.sv -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list RAM
// Generic single-port-write, single-port-read memory with registered read.
// ----------------------------------------------------------------------------
module imql_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/imql_sequencer.sv -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list sequencer
// Step counter, microcode lookup, request dispatch and conditional jumps.
// ----------------------------------------------------------------------------
`include "indexed_multi_queue_list_macros.svh"

module imql_sequencer
   import imql_pkg::*;
#(
   parameter int ITEM_COUNT = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  request_type req_data,
   input  logic        out_busy,
   input  flags_type   flags,
   output logic        req_stall,
   output logic        req_take,
   output ctrl_type    ctrl,
   output logic        step_go
);

   step_type step_ff;
   step_type step_ff_in;
   step_type entry;
   logic     queue_ok;
   logic     item_ok;

   always_comb begin
      queue_ok = {25'd0, req_data.queue_id} <= 32'(ITEM_COUNT);
      item_ok  = {26'd0, req_data.item_id} < 32'(ITEM_COUNT);
      case (req_data.req_type)
         REQ_ENQUEUE: entry = (queue_ok && item_ok) ? STEP_ENQ_READ : STEP_NOP;
         REQ_DEQUEUE: entry = queue_ok ? STEP_DEQ_READ : STEP_NOP;
         REQ_REMOVE:  entry = (queue_ok && item_ok) ? STEP_REM_READ : STEP_NOP;
         default:     entry = STEP_NOP;
      endcase
   end

   always_comb begin
      ctrl       = ucode_word(step_ff);
      step_go    = !(ctrl.done && out_busy);
      req_stall  = !ctrl.dispatch;
      req_take   = ctrl.dispatch && req_valid;
      step_ff_in = step_ff;
      if (ctrl.dispatch) begin
         if (req_valid) begin
            step_ff_in = entry;
         end
      end else if (step_go) begin
         if (cond_eval(ctrl.jmp_cond, flags)) begin
            step_ff_in = ctrl.jmp_target;
         end else begin
            step_ff_in = ctrl.next_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_CLEAR;
      end else begin
         step_ff <= step_ff_in;
      end
   end

   `IMQL_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> step_ff == STEP_CLEAR, "reset must start the clearing pass")
   `IMQL_ASSERT(a_take_leaves_idle, clock, reset, req_take |=> step_ff != STEP_IDLE, "an accepted request must start a program")

endmodule

// ----- sv/imql_datapath.sv -----
// ----------------------------------------------------------------------------
// Indexed multi-queue list datapath
// Head, tail and link memories with the address and data selection that the
// control word drives, the clearing counter and the condition flags.
// ----------------------------------------------------------------------------
`include "indexed_multi_queue_list_macros.svh"

module imql_datapath
   import imql_pkg::*;
#(
   parameter int ITEM_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_take,
   input  request_type  req_data,
   input  ctrl_type     ctrl,
   input  logic         step_go,
   output flags_type    flags,
   output response_type result
);

   localparam int ID_W = $clog2(ITEM_COUNT + 1);
   localparam int IA_W = $clog2(ITEM_COUNT);
   localparam logic [ID_W-1:0] NULL_ID = ID_W'(ITEM_COUNT);

   logic [ID_W-1:0] queue_ff;
   logic [ID_W-1:0] queue_ff_in;
   logic [IA_W-1:0] item_ff;
   logic [IA_W-1:0] item_ff_in;
   logic [ID_W-1:0] cnt_ff;
   logic [ID_W-1:0] cnt_ff_in;

   logic [ID_W+6:0] queue_wide;
   logic [IA_W+5:0] item_wide;
   logic [IA_W:0]   item_ext;
   logic [ID_W-1:0] item_val;
   logic [ID_W+6:0] head_out;
   logic [ID_W+6:0] null_out;

   logic [ID_W-1:0] head_rd;
   logic [ID_W-1:0] tail_rd;
   logic [ID_W-1:0] prev_rd;
   logic [ID_W-1:0] next_rd;

   logic            head_we;
   logic            tail_we;
   logic            prev_we;
   logic            next_we;
   logic            link_block;
   logic [ID_W-1:0] qt_waddr;
   logic [ID_W-1:0] head_wdata;
   logic [ID_W-1:0] tail_wdata;
   logic [ID_W-1:0] prev_wa_val;
   logic [ID_W-1:0] next_wa_val;
   logic [ID_W-1:0] prev_wdata;
   logic [ID_W-1:0] next_wdata;
   logic [ID_W-1:0] next_ra_val;
   logic [IA_W-1:0] prev_waddr;
   logic [IA_W-1:0] next_waddr;
   logic [IA_W-1:0] next_raddr;

   function automatic logic [ID_W-1:0] pick(src_type s, logic [ID_W-1:0] it,
                                            logic [ID_W-1:0] hd, logic [ID_W-1:0] tl,
                                            logic [ID_W-1:0] pv, logic [ID_W-1:0] nx);
      logic [ID_W-1:0] v;
      case (s)
         SRC_NULL: v = NULL_ID;
         SRC_ITEM: v = it;
         SRC_HEAD: v = hd;
         SRC_TAIL: v = tl;
         SRC_PREV: v = pv;
         SRC_NEXT: v = nx;
         default:  v = NULL_ID;
      endcase
      return v;
   endfunction

   always_comb begin
      queue_wide  = {{ID_W{1'b0}}, req_data.queue_id};
      item_wide   = {{IA_W{1'b0}}, req_data.item_id};
      queue_ff_in = req_take ? queue_wide[ID_W-1:0] : queue_ff;
      item_ff_in  = req_take ? item_wide[IA_W-1:0] : item_ff;
      item_ext    = {1'b0, item_ff};
      item_val    = item_ext[ID_W-1:0];

      flags.tail_null    = tail_rd == NULL_ID;
      flags.head_null    = head_rd == NULL_ID;
      flags.next_null    = next_rd == NULL_ID;
      flags.prev_null    = prev_rd == NULL_ID;
      flags.head_is_item = head_rd == item_val;
      flags.tail_is_item = tail_rd == item_val;
      flags.sweep_last   = cnt_ff == NULL_ID;

      cnt_ff_in = cnt_ff;
      if (ctrl.sweep && step_go) begin
         cnt_ff_in = flags.sweep_last ? '0 : cnt_ff + ID_W'(1);
      end
   end

   always_comb begin
      link_block  = ctrl.sweep && flags.sweep_last;
      head_we     = step_go && cond_eval(ctrl.head_we, flags);
      tail_we     = step_go && cond_eval(ctrl.tail_we, flags);
      prev_we     = step_go && cond_eval(ctrl.prev_we, flags) && !link_block;
      next_we     = step_go && cond_eval(ctrl.next_we, flags) && !link_block;

      qt_waddr    = ctrl.sweep ? cnt_ff : queue_ff;
      head_wdata  = pick(ctrl.head_wd, item_val, head_rd, tail_rd, prev_rd, next_rd);
      tail_wdata  = pick(ctrl.tail_wd, item_val, head_rd, tail_rd, prev_rd, next_rd);
      prev_wdata  = pick(ctrl.prev_wd, item_val, head_rd, tail_rd, prev_rd, next_rd);
      next_wdata  = pick(ctrl.next_wd, item_val, head_rd, tail_rd, prev_rd, next_rd);
      prev_wa_val = ctrl.sweep ? cnt_ff
                               : pick(ctrl.prev_wa, item_val, head_rd, tail_rd,
                                      prev_rd, next_rd);
      next_wa_val = ctrl.sweep ? cnt_ff
                               : pick(ctrl.next_wa, item_val, head_rd, tail_rd,
                                      prev_rd, next_rd);
      next_ra_val = pick(ctrl.next_ra, item_val, head_rd, tail_rd, prev_rd, next_rd);
      prev_waddr  = prev_wa_val[IA_W-1:0];
      next_waddr  = next_wa_val[IA_W-1:0];
      next_raddr  = next_ra_val[IA_W-1:0];

      head_out    = {7'd0, head_rd};
      null_out    = {7'd0, NULL_ID};
      result.popped_id = (ctrl.res == RES_POP) ? head_out[6:0] : null_out[6:0];
      result.was_empty = ctrl.res == RES_EMPTY;
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_ff_in;
      item_ff  <= item_ff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff_in;
      end
   end

   imql_ram #(
      .WIDTH  (ID_W),
      .DEPTH  (ITEM_COUNT + 1),
      .ADDR_W (ID_W)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (qt_waddr),
      .wr_data (head_wdata),
      .rd_en   (ctrl.head_rd),
      .rd_addr (queue_ff),
      .rd_data (head_rd)
   );

   imql_ram #(
      .WIDTH  (ID_W),
      .DEPTH  (ITEM_COUNT + 1),
      .ADDR_W (ID_W)
   ) u_tail_ram (
      .clock   (clock),
      .wr_en   (tail_we),
      .wr_addr (qt_waddr),
      .wr_data (tail_wdata),
      .rd_en   (ctrl.tail_rd),
      .rd_addr (queue_ff),
      .rd_data (tail_rd)
   );

   imql_ram #(
      .WIDTH  (ID_W),
      .DEPTH  (ITEM_COUNT),
      .ADDR_W (IA_W)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (ctrl.prev_rd),
      .rd_addr (item_ff),
      .rd_data (prev_rd)
   );

   imql_ram #(
      .WIDTH  (ID_W),
      .DEPTH  (ITEM_COUNT),
      .ADDR_W (IA_W)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (ctrl.next_rd),
      .rd_addr (next_raddr),
      .rd_data (next_rd)
   );

   `IMQL_ASSERT(a_pop_has_item, clock, reset, (ctrl.done && ctrl.res == RES_POP) |-> !flags.head_null, "a dequeue must not pop the null id")
   `IMQL_ASSERT(a_sweep_counts, clock, reset, (ctrl.sweep && !flags.sweep_last) |=> cnt_ff == $past(cnt_ff) + ID_W'(1), "the clearing counter must advance by one")

endmodule

// ----- sim/indexed_multi_queue_list_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed multi-queue list testbench
// Drives enqueue, dequeue and remove requests through the valid/stall request
// channel and checks every response against a transfer-level model of the
// head, tail, prev and next tables. A short directed sequence covers the
// list edge cases; random traffic then works on a tracked view of which
// items sit in which queues. Both channels idle at random, and the response
// side holds off for long stretches so that the block backs up.
// ----------------------------------------------------------------------------
module indexed_multi_queue_list_tb
   import imql_pkg::*;
();

   localparam int ITEM_COUNT = 64;
   localparam logic [6:0] NULL_ID = 7'd64;
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int RANDOM_ITEMS = 1750;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 300;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   request_type  req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   response_type rsp_data;

   request_type  pending_requests[$];
   response_type expected_responses[$];

   logic [6:0] head_of[0:ITEM_COUNT];
   logic [6:0] tail_of[0:ITEM_COUNT];
   logic [6:0] prev_of[0:ITEM_COUNT-1];
   logic [6:0] next_of[0:ITEM_COUNT-1];

   int where_q[0:ITEM_COUNT-1];
   int stamp[0:ITEM_COUNT-1];
   int stamp_next = 0;

   int error_count = 0;
   int accepted_reqs = 0;
   int cycle_count = 0;
   int gap_left = 0;
   int stall_left = 0;
   int hold_left = 0;
   int holds_done = 0;

   indexed_multi_queue_list #(
      .ITEM_COUNT(ITEM_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic response_type apply_request(request_type r);
      response_type res;
      logic [6:0] q, it, t, h, nh, p, n;
      res.popped_id = NULL_ID;
      res.was_empty = 1'b0;
      q = r.queue_id;
      it = {1'b0, r.item_id};
      if (q <= NULL_ID) begin
         case (r.req_type)
            REQ_ENQUEUE: begin
               t = tail_of[q];
               if (t >= NULL_ID) begin
                  prev_of[it] = NULL_ID;
                  head_of[q] = it;
               end else begin
                  next_of[t] = it;
                  prev_of[it] = t;
               end
               next_of[it] = NULL_ID;
               tail_of[q] = it;
            end
            REQ_DEQUEUE: begin
               h = head_of[q];
               if (h >= NULL_ID) begin
                  head_of[q] = NULL_ID;
                  tail_of[q] = NULL_ID;
                  res.was_empty = 1'b1;
               end else begin
                  nh = next_of[h];
                  head_of[q] = nh;
                  if (nh >= NULL_ID) tail_of[q] = NULL_ID;
                  else prev_of[nh] = NULL_ID;
                  prev_of[h] = NULL_ID;
                  next_of[h] = NULL_ID;
                  res.popped_id = h;
               end
            end
            REQ_REMOVE: begin
               p = prev_of[it];
               n = next_of[it];
               if (head_of[q] == it) head_of[q] = n;
               else if (p < NULL_ID) next_of[p] = n;
               if (tail_of[q] == it) tail_of[q] = p;
               else if (n < NULL_ID) prev_of[n] = p;
               prev_of[it] = NULL_ID;
               next_of[it] = NULL_ID;
            end
            default: begin
            end
         endcase
      end
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int pick_queue();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 1;
         2: return ITEM_COUNT - 1;
         3: return ITEM_COUNT;
         default: return $urandom_range(0, ITEM_COUNT);
      endcase
   endfunction

   function automatic int pick_item(bit queued);
      int cnt, k;
      cnt = 0;
      foreach (where_q[i]) if ((where_q[i] >= 0) == queued) cnt++;
      if (cnt == 0) return -1;
      k = $urandom_range(0, cnt - 1);
      foreach (where_q[i]) begin
         if ((where_q[i] >= 0) == queued) begin
            if (k == 0) return i;
            k--;
         end
      end
      return -1;
   endfunction

   task automatic add_req(logic [1:0] kind, int q, int it);
      request_type r;
      r.req_type = kind;
      r.queue_id = 7'(q);
      r.item_id = 6'(it);
      pending_requests.push_back(r);
   endtask

   task automatic build_directed();
      add_req(REQ_DEQUEUE, 0, 63);
      add_req(REQ_DEQUEUE, ITEM_COUNT, 0);
      add_req(REQ_ENQUEUE, 0, 0);
      add_req(REQ_ENQUEUE, 0, 63);
      add_req(REQ_ENQUEUE, 0, 5);
      add_req(REQ_REMOVE, 0, 63);
      add_req(REQ_REMOVE, 0, 5);
      add_req(REQ_REMOVE, 0, 0);
      add_req(REQ_ENQUEUE, ITEM_COUNT, 1);
      add_req(REQ_ENQUEUE, ITEM_COUNT, 2);
      add_req(REQ_ENQUEUE, ITEM_COUNT, 3);
      add_req(REQ_DEQUEUE, ITEM_COUNT, 42);
      add_req(REQ_DEQUEUE, ITEM_COUNT, 0);
      add_req(REQ_DEQUEUE, ITEM_COUNT, 63);
      add_req(REQ_DEQUEUE, ITEM_COUNT, 21);
      add_req(REQ_ENQUEUE, 127, 7);
      add_req(REQ_DEQUEUE, ITEM_COUNT + 1, 7);
      add_req(REQ_UNKNOWN, 0, 9);
      add_req(REQ_ENQUEUE, 1, 10);
      add_req(REQ_ENQUEUE, 1, 10);
      add_req(REQ_REMOVE, 2, 11);
      add_req(REQ_REMOVE, 3, 10);
      add_req(REQ_DEQUEUE, 1, 0);
   endtask

   task automatic build_random();
      int counted, r, q, it, oldest;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            case ($urandom_range(0, 2))
               0: add_req(2'($urandom_range(0, 3)), $urandom_range(ITEM_COUNT + 1, 127),
                          $urandom);
               1: add_req(REQ_UNKNOWN, $urandom_range(0, ITEM_COUNT), $urandom);
               default: begin
                  it = pick_item(1'b0);
                  if (it >= 0) add_req(REQ_REMOVE, pick_queue(), it);
               end
            endcase
         end else begin
            q = pick_queue();
            r = $urandom_range(0, 99);
            it = pick_item(1'b0);
            if (r < 45 && it >= 0) begin
               where_q[it] = q;
               stamp[it] = stamp_next++;
               add_req(REQ_ENQUEUE, q, it);
            end else begin
               it = pick_item(1'b1);
               if (r >= 78 && it >= 0) begin
                  add_req(REQ_REMOVE, where_q[it], it);
                  where_q[it] = -1;
               end else begin
                  if (it >= 0 && $urandom_range(0, 4) != 0) q = where_q[it];
                  oldest = -1;
                  foreach (where_q[i]) begin
                     if (where_q[i] == q && (oldest < 0 || stamp[i] < stamp[oldest]))
                        oldest = i;
                  end
                  if (oldest >= 0) where_q[oldest] = -1;
                  add_req(REQ_DEQUEUE, q, $urandom);
               end
            end
         end
         counted++;
      end
   endtask

   task automatic note_failure(string msg);
      if (error_count < 10) $display("%0t: %s", $realtime, msg);
      error_count++;
   endtask

   always @(posedge clock) begin : drive_requests
      int gap_now;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_responses.push_back(apply_request(req_data));
            accepted_reqs <= accepted_reqs + 1;
         end
         if (!(req_valid && req_stall)) begin
            gap_now = gap_left;
            if (req_valid) gap_now = ((accepted_reqs / 150) % 4 == 3) ? 0 : pick_gap();
            if (gap_now > 0 || pending_requests.size() == 0) begin
               req_valid <= 1'b0;
               gap_left <= (gap_now > 0) ? gap_now - 1 : 0;
            end else begin
               req_data <= pending_requests.pop_front();
               req_valid <= 1'b1;
               gap_left <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin : hold_responses
      if (reset) begin
         hold_left <= 0;
         holds_done <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && accepted_reqs >= 500 + holds_done * 700) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   always @(posedge clock) begin : check_responses
      response_type want;
      int stall_now;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               note_failure($sformatf("unexpected response popped_id %0d was_empty %0b",
                                      rsp_data.popped_id, rsp_data.was_empty));
            end else begin
               want = expected_responses.pop_front();
               if (rsp_data.popped_id !== want.popped_id)
                  note_failure($sformatf("popped_id expected %0d got %0d",
                                         want.popped_id, rsp_data.popped_id));
               if (rsp_data.was_empty !== want.was_empty)
                  note_failure($sformatf("was_empty expected %0b got %0b",
                                         want.was_empty, rsp_data.was_empty));
            end
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            stall_now = (cycle_count % 1024 >= 768) ? 0 : pick_gap();
            rsp_stall <= (stall_now > 0);
            stall_left <= (stall_now > 0) ? stall_now - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[indexed_multi_queue_list] ERROR");
         $finish;
      end
   end

   initial begin : run
      for (int i = 0; i <= ITEM_COUNT; i++) begin
         head_of[i] = NULL_ID;
         tail_of[i] = NULL_ID;
      end
      for (int i = 0; i < ITEM_COUNT; i++) begin
         prev_of[i] = NULL_ID;
         next_of[i] = NULL_ID;
         where_q[i] = -1;
         stamp[i] = 0;
      end
      build_directed();
      build_random();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[indexed_multi_queue_list] OK");
      end else begin
         $display("[indexed_multi_queue_list] ERROR");
      end
      $finish;
   end

endmodule
